FILE: rtl/bfkd_pkg.sv
package bfkd_pkg;

   // Default queue size
   localparam int DEFAULT_QUEUE_DEPTH = 64;

   // Field widths of the request and response items
   localparam int VALUE_W  = 8;
   localparam int POS_W    = 7;
   localparam int COUNT_W  = 7;
   localparam int STATUS_W = 2;
   localparam int KIND_W   = 2;

   // Packed stream widths, rounded up to whole bytes
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   // Request kinds carried on req_tuser
   typedef enum logic [KIND_W-1:0] {
      REQ_PUSH   = 2'd0,
      REQ_POP    = 2'd1,
      REQ_DELETE = 2'd2,
      REQ_INSERT = 2'd3
   } req_kind_type;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

endpackage

FILE: rtl/bfkd_ram.sv
module bfkd_ram #(
   parameter int DEPTH  = bfkd_pkg::DEFAULT_QUEUE_DEPTH,
   parameter int ADDR_W = $clog2(DEPTH),
   parameter int DATA_W = bfkd_pkg::VALUE_W
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write one entry, read one entry with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/byte_fifo_with_key_delete_unit.sv
// Byte queue of QUEUE_DEPTH entries held in a ring buffer in one synchronous RAM.
// Requests arrive on req_* (kind on req_tuser, end of an insert run on req_tlast),
// and each request yields exactly one response with the head byte, the entry count,
// a status and, for a delete, the number of entries removed. One request is worked
// at a time, and the next request is taken while the previous response still waits.
// Delete streams every entry through the RAM read port and writes the kept ones
// back compacted; insert moves the tail up one slot per cycle through the same port
// pair. Every request ends in S_HEAD_RD and S_HEAD_OUT, which read the head entry
// back from the RAM.
module byte_fifo_with_key_delete_unit #(
   parameter int QUEUE_DEPTH = bfkd_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // value [7:0], position [14:8], zero [15]
   input  logic [bfkd_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_type [1:0]
   input  logic [bfkd_pkg::KIND_W-1:0]     req_tuser,
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // head_value [7:0], entry_count [14:8], status [16:15], removed_count [23:17]
   output logic [bfkd_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import bfkd_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PUSH,
      S_POP,
      S_DEL,
      S_INS,
      S_PUT,
      S_HEAD_RD,
      S_HEAD_OUT
   } state_type;

   state_type            state_ff;
   logic [IDX_W-1:0]     head_ff;
   logic [CNT_W-1:0]     occ_ff;
   logic [CNT_W-1:0]     cursor_ff;
   logic                 in_run_ff;
   logic [VALUE_W-1:0]   value_ff;
   logic [CNT_W-1:0]     idx_ff;
   logic [CNT_W-1:0]     wr_ff;
   logic                 pend_ff;
   logic [CNT_W-1:0]     rm_ff;
   status_type           status_ff;

   logic                 rsp_tvalid_ff;
   logic [VALUE_W-1:0]   rsp_head_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;
   status_type           rsp_status_ff;
   logic [COUNT_W-1:0]   rsp_removed_ff;

   logic [VALUE_W-1:0]   req_value;
   logic [POS_W-1:0]     req_pos;
   logic                 full;
   logic [CMP_W-1:0]     cur_cand;
   logic [CNT_W-1:0]     cur_clamped;
   logic [CNT_W-1:0]     ins_src;

   logic                 mem_we;
   logic [IDX_W-1:0]     mem_waddr;
   logic [VALUE_W-1:0]   mem_wdata;
   logic [IDX_W-1:0]     mem_raddr;
   logic [VALUE_W-1:0]   mem_rdata;

   // Map a position counted from the head onto a ring slot
   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                input logic [CNT_W-1:0] logical);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(head) + SUM_W'(logical);
      if (sum >= SUM_W'(QUEUE_DEPTH)) begin
         sum = sum - SUM_W'(QUEUE_DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   assign req_value  = req_tdata[VALUE_W-1:0];
   assign req_pos    = req_tdata[VALUE_W +: POS_W];
   assign full       = (occ_ff >= CNT_W'(QUEUE_DEPTH));
   assign req_tready = (state_ff == S_IDLE);

   // Pick the insert slot: continue an open run, else start at position-1, clamp to count
   always_comb begin
      if (in_run_ff) begin
         cur_cand = CMP_W'(cursor_ff);
      end else if (req_pos == '0) begin
         cur_cand = '0;
      end else begin
         cur_cand = CMP_W'(req_pos - POS_W'(1));
      end
      if (cur_cand > CMP_W'(occ_ff)) begin
         cur_clamped = occ_ff;
      end else begin
         cur_clamped = cur_cand[CNT_W-1:0];
      end
   end

   assign ins_src = (idx_ff > cursor_ff) ? (idx_ff - CNT_W'(1)) : '0;

   // Drive the RAM ports from the current step
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = slot_of(head_ff, occ_ff);
      mem_wdata = value_ff;
      mem_raddr = head_ff;
      case (state_ff)
         S_PUSH: begin
            mem_we = !full;
         end
         S_DEL: begin
            mem_raddr = slot_of(head_ff, idx_ff);
            if (pend_ff && (mem_rdata != value_ff)) begin
               mem_we    = 1'b1;
               mem_waddr = slot_of(head_ff, wr_ff);
               mem_wdata = mem_rdata;
            end
         end
         S_INS: begin
            mem_raddr = slot_of(head_ff, ins_src);
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = slot_of(head_ff, wr_ff);
               mem_wdata = mem_rdata;
            end
         end
         S_PUT: begin
            mem_we    = 1'b1;
            mem_waddr = slot_of(head_ff, cursor_ff);
         end
         default: begin
            mem_raddr = head_ff;
         end
      endcase
   end

   bfkd_ram #(
      .DEPTH  (QUEUE_DEPTH),
      .ADDR_W (IDX_W),
      .DATA_W (VALUE_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Sequence each request and hold the response
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         occ_ff        <= '0;
         cursor_ff     <= '0;
         in_run_ff     <= 1'b0;
         pend_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         // Drop a taken response unless the next one replaces it this cycle
         if (rsp_tvalid_ff && rsp_tready && (state_ff != S_HEAD_OUT)) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  value_ff  <= req_value;
                  status_ff <= ST_OK;
                  rm_ff     <= '0;
                  idx_ff    <= '0;
                  wr_ff     <= '0;
                  pend_ff   <= 1'b0;
                  case (req_kind_type'(req_tuser))
                     REQ_PUSH: begin
                        in_run_ff <= 1'b0;
                        state_ff  <= S_PUSH;
                     end
                     REQ_POP: begin
                        in_run_ff <= 1'b0;
                        state_ff  <= S_POP;
                     end
                     REQ_DELETE: begin
                        in_run_ff <= 1'b0;
                        state_ff  <= S_DEL;
                     end
                     default: begin
                        cursor_ff <= cur_clamped;
                        in_run_ff <= !req_tlast;
                        if (full) begin
                           status_ff <= ST_FULL;
                           state_ff  <= S_HEAD_RD;
                        end else begin
                           idx_ff   <= occ_ff;
                           state_ff <= S_INS;
                        end
                     end
                  endcase
               end
            end
            S_PUSH: begin
               if (full) begin
                  status_ff <= ST_FULL;
               end else begin
                  occ_ff <= occ_ff + CNT_W'(1);
               end
               state_ff <= S_HEAD_RD;
            end
            S_POP: begin
               if (occ_ff == '0) begin
                  status_ff <= ST_EMPTY;
               end else begin
                  head_ff <= (head_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : head_ff + IDX_W'(1);
                  occ_ff  <= occ_ff - CNT_W'(1);
               end
               state_ff <= S_HEAD_RD;
            end
            S_DEL: begin
               // Issue the next read, then keep or drop the entry that came back
               if (idx_ff < occ_ff) begin
                  idx_ff  <= idx_ff + CNT_W'(1);
                  pend_ff <= 1'b1;
               end else begin
                  pend_ff <= 1'b0;
               end
               if (pend_ff) begin
                  if (mem_rdata == value_ff) begin
                     rm_ff <= rm_ff + CNT_W'(1);
                  end else begin
                     wr_ff <= wr_ff + CNT_W'(1);
                  end
               end
               if ((idx_ff >= occ_ff) && !pend_ff) begin
                  occ_ff   <= wr_ff;
                  state_ff <= S_HEAD_RD;
               end
            end
            S_INS: begin
               // Move entries up one slot, from the tail down to the cursor
               if (idx_ff > cursor_ff) begin
                  wr_ff   <= idx_ff;
                  idx_ff  <= idx_ff - CNT_W'(1);
                  pend_ff <= 1'b1;
               end else begin
                  pend_ff <= 1'b0;
               end
               if ((idx_ff <= cursor_ff) && !pend_ff) begin
                  state_ff <= S_PUT;
               end
            end
            S_PUT: begin
               occ_ff    <= occ_ff + CNT_W'(1);
               cursor_ff <= cursor_ff + CNT_W'(1);
               state_ff  <= S_HEAD_RD;
            end
            S_HEAD_RD: begin
               state_ff <= S_HEAD_OUT;
            end
            S_HEAD_OUT: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff  <= 1'b1;
                  rsp_head_ff    <= (occ_ff != '0) ? mem_rdata : '0;
                  rsp_count_ff   <= COUNT_W'(occ_ff);
                  rsp_status_ff  <= status_ff;
                  rsp_removed_ff <= COUNT_W'(rm_ff);
                  state_ff       <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {rsp_removed_ff, rsp_status_ff, rsp_count_ff, rsp_head_ff};

   // Occupancy never passes the queue size
   assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("occupancy above queue depth");

   // Compaction write pointer never overtakes the read pointer
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DEL) |-> (wr_ff <= idx_ff))
      else $error("delete write pointer ahead of read pointer");

   // Insert slot stays within the queue while shifting
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INS) |-> ((cursor_ff <= occ_ff) && (idx_ff <= occ_ff)))
      else $error("insert cursor beyond count");

   // An empty status is reported only with an entry count of zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && (rsp_status_ff == ST_EMPTY)) |-> (rsp_count_ff == '0))
      else $error("empty status with entries present");

   // A taken request closes the input until its work is done
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while busy");

endmodule
